// ===== sv/bounded_sorted_list_table_top_macros.svh =====
// Assertion macros shared by the list table RTL.
`ifndef BOUNDED_SORTED_LIST_TABLE_TOP_MACROS_SVH
`define BOUNDED_SORTED_LIST_TABLE_TOP_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define BLST_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define BLST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/blst_pkg.sv =====
package blst_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_GET    = 3'd1,
        ACT_SET    = 3'd2,
        ACT_INSERT = 3'd3,
        ACT_SORTED = 3'd4,
        ACT_REMOVE = 3'd5
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    // Operation broadcast to every cell of the row at once.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_SORTED,
        CELL_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [IDX_W-1:0]      pos;
        logic [CNT_W-1:0]      count;
        logic [WORD_BITS-1:0]  value;
    } t_cell_ctl;

endpackage

// ===== sv/blst_cell.sv =====
module blst_cell (
    input  logic                          i_clk,
    input  logic [blst_pkg::IDX_W-1:0]    i_cell_idx,
    input  blst_pkg::t_cell_ctl           i_ctl,
    input  logic [blst_pkg::WORD_BITS-1:0] i_left,
    input  logic [blst_pkg::WORD_BITS-1:0] i_right,
    input  logic                          i_pre_gt,
    output logic                          o_pre_gt,
    output logic [blst_pkg::WORD_BITS-1:0] o_data,
    output logic [blst_pkg::WORD_BITS-1:0] o_sel_data
);
    import blst_pkg::*;

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic                 match;
    logic                 below;
    logic                 gt;

    assign match = (i_cell_idx == i_ctl.pos);
    assign below = (i_cell_idx < i_ctl.pos);
    // The new word sorts after this entry only if the entry is live and greater.
    assign gt = (CNT_W'(i_cell_idx) < i_ctl.count) &&
                ($signed(i_ctl.value) < $signed(r_data));
    assign o_pre_gt   = i_pre_gt & gt;
    assign o_data     = r_data;
    assign o_sel_data = match ? r_data : '0;

    always_comb begin
        unique case (i_ctl.op)
            CELL_WRITE:  n_data = match ? i_ctl.value : r_data;
            CELL_INSERT: n_data = below ? r_data : (match ? i_ctl.value : i_left);
            CELL_SORTED: n_data = o_pre_gt ? r_data : (i_pre_gt ? i_ctl.value : i_left);
            CELL_REMOVE: n_data = below ? r_data : i_right;
            default:     n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// ===== sv/blst_chain.sv =====
module blst_chain (
    input  logic                           i_clk,
    input  blst_pkg::t_cell_ctl            i_ctl,
    output logic [blst_pkg::WORD_BITS-1:0] o_read_data
);
    import blst_pkg::*;

    logic [WORD_BITS-1:0] w_data [DEPTH];
    logic [WORD_BITS-1:0] w_sel  [DEPTH];
    logic                 w_pre  [DEPTH+1];

    assign w_pre[0] = 1'b1;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] left;
        logic [WORD_BITS-1:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_inner_l
            assign left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right = w_data[g];
        end else begin : g_inner_r
            assign right = w_data[g+1];
        end
        blst_cell u_cell (
            .i_clk      (i_clk),
            .i_cell_idx (IDX_W'(g)),
            .i_ctl      (i_ctl),
            .i_left     (left),
            .i_right    (right),
            .i_pre_gt   (w_pre[g]),
            .o_pre_gt   (w_pre[g+1]),
            .o_data     (w_data[g]),
            .o_sel_data (w_sel[g])
        );
    end

    // Only the addressed cell drives a nonzero word, so an OR gathers the read.
    always_comb begin
        o_read_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            o_read_data = o_read_data | w_sel[k];
        end
    end

endmodule

// ===== sv/bounded_sorted_list_table_top.sv =====
// Bounded sorted list table.
// The block keeps a packed list of signed words in a row of cells. Each cell
// holds one entry and, on every operation, either keeps its word, loads the
// new word, or takes its left or right neighbor, so insert, sorted insert and
// remove act on the whole row at once. An item on the input channel (i_in_valid,
// o_in_stall) carries an action, an index and a value; one result per item
// leaves on the output channel (o_out_valid, i_out_stall).
// The result is registered and valid in the cycle after the transfer.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single cell update and the output register; sorted insert resolves its
// position through a ripple of per-cell compares along the row.
// When the receiver stalls, the result is held and o_in_stall rises until the
// output register is drained, so no result is lost or overwritten.
// The capacity register is written through i_cfg_valid/o_cfg_ready, which is
// always ready; a written 0 acts as 1 and a value above the depth as the depth.
// Reset empties the list and sets the capacity to the depth; entry words are
// not cleared since only entries below the count are ever read.
`include "bounded_sorted_list_table_top_macros.svh"
module bounded_sorted_list_table_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [blst_pkg::ACT_W-1:0]     i_action,
    input  logic [blst_pkg::IDX_W-1:0]     i_index,
    input  logic [blst_pkg::WORD_BITS-1:0] i_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [blst_pkg::WORD_BITS-1:0] o_read_value,
    output logic [blst_pkg::STAT_W-1:0]    o_status,
    output logic [blst_pkg::CNT_W-1:0]     o_entry_count,
    output logic                           o_is_full,
    output logic                           o_is_empty,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [blst_pkg::CNT_W-1:0]     i_cfg_capacity
);
    import blst_pkg::*;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     r_cap;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_read_value;
    t_status              r_status;
    logic [CNT_W-1:0]     r_entry_count;
    logic                 r_is_full;

    logic                 in_accept;
    logic                 full;
    logic                 idx_live;
    logic                 take_read;
    t_status              n_status;
    t_cell_ctl            ctl;
    logic [WORD_BITS-1:0] read_data;

    // A new item is taken whenever the output register is free or drains now.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign full     = (r_count >= r_cap);
    assign idx_live = (CNT_W'(i_index) < r_count);

    // Decode the action into a row operation, a status and the new count.
    always_comb begin
        ctl.op    = CELL_HOLD;
        ctl.pos   = i_index;
        ctl.count = r_count;
        ctl.value = i_value;
        n_status  = ST_DONE;
        n_count   = r_count;
        take_read = 1'b0;
        unique case (t_action'(i_action))
            ACT_APPEND: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.op  = CELL_INSERT;
                    ctl.pos = r_count[IDX_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_GET: begin
                if (!idx_live) n_status = ST_BAD_INDEX;
                else take_read = 1'b1;
            end
            ACT_SET: begin
                if (!idx_live) n_status = ST_BAD_INDEX;
                else ctl.op = CELL_WRITE;
            end
            ACT_INSERT: begin
                // The range check comes before the full check.
                if (CNT_W'(i_index) > r_count) begin
                    n_status = ST_BAD_INDEX;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.op  = CELL_INSERT;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_SORTED: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.op  = CELL_SORTED;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_REMOVE: begin
                if (!idx_live) begin
                    n_status = ST_BAD_INDEX;
                end else begin
                    ctl.op    = CELL_REMOVE;
                    take_read = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
                // Unused action codes leave the list untouched.
            end
        endcase
        if (!in_accept) begin
            ctl.op = CELL_HOLD;
        end
    end

    blst_chain u_chain (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .o_read_data (read_data)
    );

    // Control state: count, capacity and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CNT_W'(DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_count <= n_count;
            end
            if (i_cfg_valid) begin
                if (i_cfg_capacity == '0) begin
                    r_cap <= CNT_W'(1);
                end else if (i_cfg_capacity > CNT_W'(DEPTH)) begin
                    r_cap <= CNT_W'(DEPTH);
                end else begin
                    r_cap <= i_cfg_capacity;
                end
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded on each transfer in.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_read_value  <= take_read ? read_data : '0;
            r_status      <= n_status;
            r_entry_count <= n_count;
            r_is_full     <= (n_count >= r_cap);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_is_full     = r_is_full;
    assign o_is_empty    = (r_entry_count == '0);

    `BLST_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(DEPTH), "count exceeds depth")
    `BLST_ASSERT_NEXT(a_full_keeps, in_accept && n_status == ST_FULL, $stable(r_count), "count moved")
    `BLST_ASSERT_NEXT(a_result_follows, in_accept, o_out_valid && r_entry_count == r_count, "no result")

endmodule
